// ===== hdl/sorted_timer_queue_unit_assert.svh =====
// Assertion macros shared by the sorted timer queue RTL.
`ifndef SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH
`define SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STQ_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/stq_pkg.sv =====
// Types and codes of the sorted timer queue.
`default_nettype none

package stq_pkg;

	localparam int OUT_HANDLE_BITS = 8;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_ADJUST = 2'd1,
		OP_DELETE = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_DUP       = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    look;
		logic    insert;
		logic    remove;
		logic    pop;
		logic    emit;
		status_t status;
		logic    exp_valid;
		logic    last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic found;
		logic full;
		logic head_exp;
		logic next_exp;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hdl/stq_if.sv =====
// Request and response channel interfaces of the sorted timer queue.
`default_nettype none

interface stq_in_if #(
	parameter int HANDLE_BITS = 8,
	parameter int TIME_BITS   = 32
) ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             op;
	logic [HANDLE_BITS-1:0] handle;
	logic [TIME_BITS-1:0]   expire_time;
	logic [TIME_BITS-1:0]   now;

	modport source (output valid, op, handle, expire_time, now, input ready);
	modport sink (input valid, op, handle, expire_time, now, output ready);
endinterface

interface stq_out_if ();
	logic                                valid;
	logic                                ready;
	logic [1:0]                          status;
	logic                                expired_valid;
	logic [stq_pkg::OUT_HANDLE_BITS-1:0] expired_handle;
	logic                                last;

	modport source (output valid, status, expired_valid, expired_handle, last, input ready);
	modport sink (input valid, status, expired_valid, expired_handle, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/sorted_timer_queue_unit.sv =====
// Top level of the sorted timer queue.
//
// req carries one operation per transaction: add, adjust expiry, delete, or
// tick with the current time. rsp returns one transaction for add, adjust and
// delete (status only, last set), and for tick one transaction per expired
// timer in expiry order with last on the final one, or a single empty
// transaction when nothing has expired.
// Timing: the controller takes one request at a time. A request passes a
// lookup state and then an update state; the response register loads at the end
// of the update state and req.ready returns the cycle after. Adjust adds a
// reinsert state (remove, then reinsert), and tick pops the head cell once
// per expired timer, one pop per cycle while rsp is free, or emits one
// empty response when nothing has expired.
// The lookup compares all cells against the handle at once; insertion and
// removal shift the cells from the affected position on by one place at once.
// Reset empties the queue; stored cells need no clearing.
// A stalled rsp holds its transaction and the controller waits to update.
`default_nettype none

module sorted_timer_queue_unit #(
	parameter int DEPTH       = 16,
	parameter int HANDLE_BITS = 8,
	parameter int TIME_BITS   = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	stq_in_if.sink    req,
	stq_out_if.source rsp
);

	`include "sorted_timer_queue_unit_assert.svh"

	stq_pkg::cmd_t cmd;
	stq_pkg::sts_t sts;
	logic          ready;

	assign req.ready = ready;

	stq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stq_dp #(
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.op             (req.op),
		.handle         (req.handle),
		.expire_time    (req.expire_time),
		.now            (req.now),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.status         (rsp.status),
		.expired_valid  (rsp.expired_valid),
		.expired_handle (rsp.expired_handle),
		.last           (rsp.last)
	);

	`STQ_ASSERT_NEXT(a_one_request, clk, arst_n, req.valid && req.ready, !req.ready, "request taken while busy")
	`STQ_ASSERT_SAME(a_empty_is_last, clk, arst_n, rsp.valid && !rsp.expired_valid, rsp.last, "non-expiry response without last")
	`STQ_ASSERT_SAME(a_expired_ok, clk, arst_n, rsp.valid && rsp.expired_valid, rsp.status == stq_pkg::ST_OK, "expired timer with error status")
	`STQ_ASSERT_SAME(a_no_insert_full, clk, arst_n, cmd.insert, !sts.full, "insert into full queue")

endmodule

`default_nettype wire

// ===== hdl/stq_dp.sv =====
// Datapath: sorted timer cells, operand latches, lookup and response register.
`default_nettype none

module stq_dp #(
	parameter int DEPTH       = 16,
	parameter int HANDLE_BITS = 8,
	parameter int TIME_BITS   = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire stq_pkg::cmd_t                       cmd,
	output stq_pkg::sts_t                            sts,
	input  wire logic [1:0]                          op,
	input  wire logic [HANDLE_BITS-1:0]              handle,
	input  wire logic [TIME_BITS-1:0]                expire_time,
	input  wire logic [TIME_BITS-1:0]                now,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               status,
	output logic                                     expired_valid,
	output logic [stq_pkg::OUT_HANDLE_BITS-1:0]      expired_handle,
	output logic                                     last
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	logic [TIME_BITS-1:0]   exp_q [DEPTH];
	logic [HANDLE_BITS-1:0] hdl_q [DEPTH];
	logic [CNT_W-1:0]       cnt_q;

	stq_pkg::op_t           op_q;
	logic [HANDLE_BITS-1:0] h_q;
	logic [TIME_BITS-1:0]   e_q;
	logic [TIME_BITS-1:0]   now_q;
	logic                   found_q;
	logic [IDX_W-1:0]       pos_q;

	logic                   found_c;
	logic [IDX_W-1:0]       pos_c;
	logic [DEPTH-1:0]       gt;

	logic [HANDLE_BITS+stq_pkg::OUT_HANDLE_BITS-1:0] head_ext;
	logic                                            out_valid_q;

	// Latch the operands of the accepted transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= stq_pkg::op_t'(op);
			h_q   <= handle;
			e_q   <= expire_time;
			now_q <= now;
		end
	end

	// Handles are unique, so at most one cell matches: OR its index together.
	always_comb begin
		found_c = 1'b0;
		pos_c   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if ((CNT_W'(i) < cnt_q) && (hdl_q[i] == h_q)) begin
				found_c = 1'b1;
				pos_c   = pos_c | IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			found_q <= found_c;
			pos_q   <= pos_c;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic                   ins_prev;
		logic                   first;
		logic [TIME_BITS-1:0]   prev_e;
		logic [HANDLE_BITS-1:0] prev_h;
		logic [TIME_BITS-1:0]   next_e;
		logic [HANDLE_BITS-1:0] next_h;

		// Empty cells count as later than any new expiry.
		assign gt[g] = !(CNT_W'(g) < cnt_q) || (exp_q[g] > e_q);

		if (g == 0) begin : g_head
			assign ins_prev = 1'b0;
			assign prev_e   = e_q;
			assign prev_h   = h_q;
		end else begin : g_body
			assign ins_prev = gt[g-1];
			assign prev_e   = exp_q[g-1];
			assign prev_h   = hdl_q[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign next_e = exp_q[g];
			assign next_h = hdl_q[g];
		end else begin : g_inner
			assign next_e = exp_q[g+1];
			assign next_h = hdl_q[g+1];
		end

		assign first = gt[g] && !ins_prev;

		always_ff @(posedge clk) begin
			if (cmd.insert) begin
				if (first) begin
					exp_q[g] <= e_q;
					hdl_q[g] <= h_q;
				end else if (ins_prev) begin
					exp_q[g] <= prev_e;
					hdl_q[g] <= prev_h;
				end
			end else if ((cmd.remove && (IDX_W'(g) >= pos_q)) || cmd.pop) begin
				exp_q[g] <= next_e;
				hdl_q[g] <= next_h;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.insert) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.remove || cmd.pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign head_ext = {{stq_pkg::OUT_HANDLE_BITS{1'b0}}, hdl_q[0]};

	// Response register: refill when empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status         <= cmd.status;
			expired_valid  <= cmd.exp_valid;
			expired_handle <= cmd.exp_valid ? head_ext[stq_pkg::OUT_HANDLE_BITS-1:0] : '0;
			last           <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.op       = op_q;
		sts.found    = found_q;
		sts.full     = (cnt_q == CNT_W'(DEPTH));
		sts.head_exp = (cnt_q != '0) && (exp_q[0] <= now_q);
		sts.next_exp = (cnt_q > CNT_W'(1)) && (exp_q[1] <= now_q);
		sts.out_free = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

// ===== hdl/stq_ctrl.sv =====
// Controller: sequences lookup, update and response of each transaction.
`default_nettype none

module stq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire stq_pkg::sts_t sts,
	output stq_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_APPLY,
		S_REINS,
		S_TICK
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign in_ready = ready_q;

	always_comb begin
		cmd        = '0;
		cmd.status = stq_pkg::ST_OK;
		cmd.load   = ready_q && in_valid;
		unique case (state_q)
			S_IDLE: begin
			end
			S_LOOK: begin
				cmd.look = 1'b1;
			end
			S_APPLY: begin
				if (sts.out_free) begin
					unique case (sts.op)
						stq_pkg::OP_ADD: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							if (sts.found) begin
								cmd.status = stq_pkg::ST_DUP;
							end else if (sts.full) begin
								cmd.status = stq_pkg::ST_FULL;
							end else begin
								cmd.insert = 1'b1;
							end
						end
						stq_pkg::OP_ADJUST: begin
							// reinsert and respond from S_REINS
							if (sts.found) begin
								cmd.remove = 1'b1;
							end else begin
								cmd.emit   = 1'b1;
								cmd.last   = 1'b1;
								cmd.status = stq_pkg::ST_NOT_FOUND;
							end
						end
						stq_pkg::OP_DELETE: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							if (sts.found) begin
								cmd.remove = 1'b1;
							end else begin
								cmd.status = stq_pkg::ST_NOT_FOUND;
							end
						end
						stq_pkg::OP_TICK: begin
						end
					endcase
				end
			end
			S_REINS: begin
				if (sts.out_free) begin
					cmd.insert = 1'b1;
					cmd.emit   = 1'b1;
					cmd.last   = 1'b1;
				end
			end
			S_TICK: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.head_exp) begin
						cmd.pop       = 1'b1;
						cmd.exp_valid = 1'b1;
						cmd.last      = !sts.next_exp;
					end else begin
						cmd.last = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_LOOK;
						ready_q <= 1'b0;
					end
				end
				S_LOOK: begin
					state_q <= (sts.op == stq_pkg::OP_TICK) ? S_TICK : S_APPLY;
				end
				S_APPLY: begin
					if (sts.out_free) begin
						if ((sts.op == stq_pkg::OP_ADJUST) && sts.found) begin
							state_q <= S_REINS;
						end else begin
							state_q <= S_IDLE;
							ready_q <= 1'b1;
						end
					end
				end
				S_REINS: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_TICK: begin
					if (cmd.emit && cmd.last) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
